// File: rtl/assert_macros.svh
// Assertion helpers for the RTL (used by edft_ctrl). Bodies compile away in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true on a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// File: rtl/edft_pkg.sv
package edft_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_TASKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZON      = 1'd1;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [3:0]  task_slot;
    logic [15:0] task_period;
    logic [15:0] task_burst;
  } req_t;

  typedef struct packed {
    logic        idle;
    logic [3:0]  chosen_slot;
    logic [15:0] work_before;
    logic        job_done;
    logic        on_boundary;
    logic [15:0] finished_count;
    logic [15:0] killed_count;
  } res_t;

  typedef struct packed {
    logic [4:0]  active_tasks;
    logic [30:0] horizon;
  } cfg_t;

  // One task slot as stored in the table RAM.
  typedef struct packed {
    logic [15:0] period;
    logic [15:0] burst;
    logic [15:0] work;
    logic [31:0] deadline;
    logic [15:0] phase;
    logic [15:0] finished;
    logic [15:0] killed;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    sat_inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Phase advances each tick and wraps at the period.
  function automatic logic [15:0] phase_step(input logic [15:0] phase,
                                             input logic [15:0] period);
    logic [16:0] ph;
    ph = {1'b0, phase} + 17'd1;
    phase_step = (ph >= {1'b0, period}) ? 16'd0 : ph[15:0];
  endfunction

endpackage

// File: rtl/edft_stream_if.sv
interface edft_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// File: rtl/edft_ram.sv
module edft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/edft_ctrl.sv
`include "assert_macros.svh"

module edft_ctrl #(
  parameter int NUM_SLOTS = 16
) (
  input  logic            clk,
  input  logic            rst,
  edft_stream_if.sink     req,
  input  edft_pkg::cfg_t  cfg,
  output logic            res_valid,
  input  logic            res_ready,
  output edft_pkg::res_t  res
);

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam logic [CW-1:0] CNT_END  = CW'(NUM_SLOTS);
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_SLOTS - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]          state;
  logic [CW-1:0]       rd_cnt;
  logic                chk_vld;
  logic [AW-1:0]       chk_idx;
  logic                found;
  logic [AW-1:0]       best_idx;
  edft_pkg::row_t      best_row;
  edft_pkg::res_t      res_q;

  logic                accept;
  logic [6:0]          slot_ext;
  logic                slot_ok;
  logic [31:0]         cap;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  edft_pkg::row_t      rd_row;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  edft_pkg::row_t      ram_wdata;
  edft_pkg::row_t      load_row;
  edft_pkg::row_t      scan_row;
  edft_pkg::row_t      upd_row;
  edft_pkg::res_t      upd_res;
  logic                elig;
  logic [15:0]         work_dec;
  logic                done;
  logic                boundary;
  logic [32:0]         dl_sum;
  logic [31:0]         dl_new;
  logic [6:0]          best_ext;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign slot_ext  = 7'(req.payload.task_slot);
  assign slot_ok   = slot_ext < 7'(NUM_SLOTS);
  assign cap       = {1'b0, cfg.horizon} + 32'd1;

  assign rd_en   = (state == S_SCAN) && (rd_cnt != CNT_END);
  assign rd_addr = rd_cnt[AW-1:0];

  edft_ram #(
    .WIDTH(edft_pkg::ROW_W),
    .DEPTH(NUM_SLOTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_row)
  );

  always_comb begin
    load_row          = '0;
    load_row.period   = req.payload.task_period;
    load_row.burst    = req.payload.task_burst;
    load_row.work     = req.payload.task_burst;
    load_row.deadline = {16'd0, req.payload.task_period};
  end

  // Compare stage of the scan: one row per cycle against the running best.
  always_comb begin
    elig = chk_vld
        && (7'(chk_idx) < 7'(cfg.active_tasks))
        && (rd_row.work != 16'd0)
        && (rd_row.deadline <= cap)
        && (!found || rd_row.deadline <= best_row.deadline);
    scan_row       = rd_row;
    scan_row.phase = edft_pkg::phase_step(rd_row.phase, rd_row.period);
  end

  always_comb begin
    work_dec = best_row.work - 16'd1;
    done     = (work_dec == 16'd0);
    boundary = (best_row.phase == 16'd0);
    dl_sum   = {1'b0, best_row.deadline} + 33'(best_row.period);
    dl_new   = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];
    best_ext = 7'(best_idx);

    upd_row          = best_row;
    upd_row.phase    = edft_pkg::phase_step(best_row.phase, best_row.period);
    upd_row.work     = done ? best_row.burst : work_dec;
    upd_row.deadline = done ? dl_new : best_row.deadline;
    if (done && boundary) begin
      upd_row.finished = edft_pkg::sat_inc16(best_row.finished);
    end
    if (done && !boundary) begin
      upd_row.killed = edft_pkg::sat_inc16(best_row.killed);
    end

    upd_res = '0;
    if (!found) begin
      upd_res.idle = 1'b1;
    end else begin
      upd_res.chosen_slot    = best_ext[3:0];
      upd_res.work_before    = best_row.work;
      upd_res.job_done       = done;
      upd_res.on_boundary    = done && boundary;
      upd_res.finished_count = upd_row.finished;
      upd_res.killed_count   = upd_row.killed;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_idx;
    ram_wdata = scan_row;
    unique case (state)
      S_IDLE: begin
        ram_we    = accept && (req.payload.kind == edft_pkg::KIND_LOAD) && slot_ok;
        ram_waddr = slot_ext[AW-1:0];
        ram_wdata = load_row;
      end
      S_SCAN: begin
        ram_we    = chk_vld;
        ram_waddr = chk_idx;
        ram_wdata = scan_row;
      end
      S_UPDATE: begin
        ram_we    = found;
        ram_waddr = best_idx;
        ram_wdata = upd_row;
      end
      S_EMIT: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_cnt  <= '0;
      chk_vld <= 1'b0;
      found   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && req.payload.kind == edft_pkg::KIND_TICK) begin
            state   <= S_SCAN;
            rd_cnt  <= '0;
            chk_vld <= 1'b0;
            found   <= 1'b0;
          end
        end
        S_SCAN: begin
          chk_vld <= rd_en;
          if (rd_en) begin
            rd_cnt <= rd_cnt + CW'(1);
          end
          if (elig) begin
            found <= 1'b1;
          end
          if (chk_vld && chk_idx == LAST_IDX) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      chk_idx <= rd_addr;
    end
    if (state == S_SCAN && elig) begin
      best_idx <= chk_idx;
      best_row <= rd_row;
    end
    if (state == S_UPDATE) begin
      res_q <= upd_res;
    end
  end

  assign res_valid = (state == S_EMIT);
  assign res       = res_q;

  `ASSERT_CLK(a_best_under_cap, clk, rst, (state == S_UPDATE && found) |-> (best_row.deadline <= cap), "chosen deadline above horizon")
  `ASSERT_NEVER(a_rw_collision, clk, rst, rd_en && ram_we && (ram_waddr == rd_addr), "table read and write hit the same slot")
  `ASSERT_CLK(a_emit_after_update, clk, rst, $rose(res_valid) |-> ($past(state) == S_UPDATE), "result raised without an update step")

endmodule

// File: rtl/edf_tick_scheduler.sv
// Earliest-deadline-first tick scheduler over a table of NUM_SLOTS task slots.
// req carries items: kind selects a load (writes one slot's period and burst,
// resets its deadline, work, phase and job counters) or a tick.
// rsp carries one result per tick; loads give no result.
// Configuration (cfg_we/cfg_index/cfg_data): index 0 active_tasks, 1 horizon;
// write only while no tick is in flight.
// A load is written to its slot as it is accepted and leaves req.ready high. A tick
// reads every slot of the table RAM once through one compare unit (one slot per
// cycle, with a registered read), writes each slot back with its phase stepped,
// then writes the chosen slot, if any, back and hands the result to the output
// register; req.ready stays low from the accepted tick until that hand-off, so a
// new item is taken only once the table walk of the last tick is through.
// rsp is a register stage: a new item is taken while a result waits there; if
// the receiver stalls, the next tick holds at its end until the stage frees up.
// Synchronous reset clears control state, the configuration and rsp.valid; table
// contents are undefined until each slot is loaded.
module edf_tick_scheduler #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  edft_stream_if.sink                      req,
  edft_stream_if.source                    rsp,
  input  logic                             cfg_we,
  input  logic [edft_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [edft_pkg::CFG_DATA_W-1:0]  cfg_data
);

  edft_pkg::cfg_t cfg;
  edft_pkg::res_t res;
  logic           res_valid;
  logic           res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        edft_pkg::REG_ACTIVE_TASKS: cfg.active_tasks <= cfg_data[4:0];
        edft_pkg::REG_HORIZON:      cfg.horizon      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  edft_ctrl #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg      (cfg),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assign res_ready = res_valid && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_ready) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready) begin
      rsp.payload <= res;
    end
  end

endmodule

// File: sim/edft_sched_checker.sv
module edft_sched_checker #(
  parameter int NUM_SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  input  logic                            req_ready,
  input  edft_pkg::req_t                  req_item,
  input  logic                            rsp_valid,
  input  logic                            rsp_ready,
  input  edft_pkg::res_t                  rsp_item,
  input  logic                            cfg_we,
  input  logic [edft_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [edft_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                     outstanding,
  output int unsigned                     mismatches,
  output int unsigned                     results_seen,
  output int unsigned                     jobs_seen
);

  logic [4:0]  sel_count;
  logic [30:0] horizon_q;

  logic [15:0] slot_period[NUM_SLOTS];
  logic [15:0] slot_burst[NUM_SLOTS];
  logic [15:0] slot_work[NUM_SLOTS];
  logic [31:0] slot_deadline[NUM_SLOTS];
  logic [15:0] slot_phase[NUM_SLOTS];
  logic [15:0] slot_finished[NUM_SLOTS];
  logic [15:0] slot_killed[NUM_SLOTS];

  edft_pkg::res_t pending_results[$];
  int unsigned    err_cnt;
  int unsigned    seen_cnt;
  int unsigned    job_cnt;

  function automatic void load_slot(input edft_pkg::req_t it);
    int s;
    s = int'(it.task_slot);
    if (s < NUM_SLOTS) begin
      slot_period[s]   = it.task_period;
      slot_burst[s]    = it.task_burst;
      slot_work[s]     = it.task_burst;
      slot_deadline[s] = {16'd0, it.task_period};
      slot_phase[s]    = '0;
      slot_finished[s] = '0;
      slot_killed[s]   = '0;
    end
  endfunction

  // Earliest deadline among eligible slots, ties to the highest index.
  function automatic edft_pkg::res_t schedule_tick();
    edft_pkg::res_t r;
    int             limit;
    int             best;
    bit             found;
    logic [31:0]    best_dl;
    logic [32:0]    cap;
    logic [32:0]    next_dl;
    logic [16:0]    ph;
    logic [15:0]    wb;
    r       = '0;
    best    = 0;
    found   = 1'b0;
    best_dl = '0;
    cap     = {2'b0, horizon_q} + 33'd1;
    limit   = (int'(sel_count) < NUM_SLOTS) ? int'(sel_count) : NUM_SLOTS;
    for (int i = 0; i < limit; i++) begin
      if (slot_work[i] != 16'd0 && {1'b0, slot_deadline[i]} <= cap &&
          (!found || slot_deadline[i] <= best_dl)) begin
        found   = 1'b1;
        best_dl = slot_deadline[i];
        best    = i;
      end
    end
    if (!found) begin
      r.idle = 1'b1;
    end else begin
      wb              = slot_work[best];
      r.chosen_slot   = best[3:0];
      r.work_before   = wb;
      slot_work[best] = wb - 16'd1;
      if (slot_work[best] == 16'd0) begin
        r.job_done    = 1'b1;
        r.on_boundary = (slot_phase[best] == 16'd0);
        if (r.on_boundary) begin
          if (slot_finished[best] != 16'hFFFF) slot_finished[best] = slot_finished[best] + 16'd1;
        end else begin
          if (slot_killed[best] != 16'hFFFF) slot_killed[best] = slot_killed[best] + 16'd1;
        end
        next_dl = {1'b0, slot_deadline[best]} + {17'd0, slot_period[best]};
        slot_deadline[best] = next_dl[32] ? 32'hFFFF_FFFF : next_dl[31:0];
        slot_work[best]     = slot_burst[best];
      end
      r.finished_count = slot_finished[best];
      r.killed_count   = slot_killed[best];
    end
    // phase runs on every tick, idle or not
    for (int i = 0; i < NUM_SLOTS; i++) begin
      ph = {1'b0, slot_phase[i]} + 17'd1;
      slot_phase[i] = (ph >= {1'b0, slot_period[i]}) ? 16'd0 : ph[15:0];
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= 40)
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    edft_pkg::res_t want;
    if (rst) begin
      sel_count = '0;
      horizon_q = '0;
      pending_results.delete();
      err_cnt  = 0;
      seen_cnt = 0;
      job_cnt  = 0;
    end else begin
      // results first, so a transaction in the same cycle cannot hide a stray one
      if (rsp_valid && rsp_ready) begin
        seen_cnt++;
        if (rsp_item.job_done === 1'b1) job_cnt++;
        if (pending_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 40)
            $display("%0t: unexpected result: expected none, actual 0x%0h", $time, rsp_item);
        end else begin
          want = pending_results.pop_front();
          compare_field("idle", 32'(want.idle), 32'(rsp_item.idle));
          compare_field("chosen_slot", 32'(want.chosen_slot), 32'(rsp_item.chosen_slot));
          compare_field("work_before", 32'(want.work_before), 32'(rsp_item.work_before));
          compare_field("job_done", 32'(want.job_done), 32'(rsp_item.job_done));
          compare_field("on_boundary", 32'(want.on_boundary), 32'(rsp_item.on_boundary));
          compare_field("finished_count", 32'(want.finished_count),
                        32'(rsp_item.finished_count));
          compare_field("killed_count", 32'(want.killed_count),
                        32'(rsp_item.killed_count));
        end
      end
      if (req_valid && req_ready) begin
        if (req_item.kind == edft_pkg::KIND_LOAD) load_slot(req_item);
        else pending_results.push_back(schedule_tick());
      end
      if (cfg_we) begin
        case (cfg_index)
          edft_pkg::REG_ACTIVE_TASKS: sel_count = cfg_data[4:0];
          edft_pkg::REG_HORIZON:      horizon_q = cfg_data[30:0];
          default: ;
        endcase
      end
    end
    outstanding  <= pending_results.size();
    mismatches   <= err_cnt;
    results_seen <= seen_cnt;
    jobs_seen    <= job_cnt;
  end

endmodule

// File: sim/tb_edf_tick_scheduler.sv
module tb_edf_tick_scheduler;

  localparam int NUM_SLOTS = 16;
  localparam int LATENCY   = NUM_SLOTS + 4;
  localparam int PHASES    = 8;
  localparam int PHASE_LEN = 200;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [edft_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [edft_pkg::CFG_DATA_W-1:0] cfg_data;

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned outstanding;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned jobs_seen;
  int unsigned ticks_sent;
  int unsigned loads_sent;

  edft_stream_if #(.payload_t(edft_pkg::req_t)) req_if ();
  edft_stream_if #(.payload_t(edft_pkg::res_t)) rsp_if ();

  edf_tick_scheduler #(.NUM_SLOTS(NUM_SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  edft_sched_checker #(.NUM_SLOTS(NUM_SLOTS)) chk (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_if.valid),
    .req_ready    (req_if.ready),
    .req_item     (req_if.payload),
    .rsp_valid    (rsp_if.valid),
    .rsp_ready    (rsp_if.ready),
    .rsp_item     (rsp_if.payload),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .outstanding  (outstanding),
    .mismatches   (mismatches),
    .results_seen (results_seen),
    .jobs_seen    (jobs_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Holds valid across back-to-back transactions; only drops it for a gap.
  task automatic send(input edft_pkg::req_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= it;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    if (it.kind == edft_pkg::KIND_LOAD) loads_sent++;
    else ticks_sent++;
  endtask

  task automatic send_load(input logic [3:0] s, input logic [15:0] p, input logic [15:0] b);
    edft_pkg::req_t it;
    it.kind        = edft_pkg::KIND_LOAD;
    it.task_slot   = s;
    it.task_period = p;
    it.task_burst  = b;
    send(it);
  endtask

  task automatic send_tick();
    edft_pkg::req_t it;
    it.kind        = edft_pkg::KIND_TICK;
    it.task_slot   = 4'($urandom);
    it.task_period = 16'($urandom);
    it.task_burst  = 16'($urandom);
    send(it);
  endtask

  function automatic edft_pkg::req_t rand_load(input logic [3:0] s);
    edft_pkg::req_t it;
    it.kind        = edft_pkg::KIND_LOAD;
    it.task_slot   = s;
    it.task_period = ($urandom_range(99) < 8) ? 16'($urandom_range(65535, 1))
                                              : 16'($urandom_range(12, 1));
    it.task_burst  = ($urandom_range(99) < 8) ? 16'($urandom_range(65535, 0))
                                              : 16'($urandom_range(5, 0));
    return it;
  endfunction

  task automatic drain();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // loads give no result, so allow for one still in flight
  task automatic settle();
    drain();
    repeat (2 * LATENCY) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [4:0] active, input logic [30:0] hz);
    cfg_we    <= 1'b1;
    cfg_index <= edft_pkg::REG_ACTIVE_TASKS;
    cfg_data  <= edft_pkg::CFG_DATA_W'(active);
    @(posedge clk);
    cfg_index <= edft_pkg::REG_HORIZON;
    cfg_data  <= hz;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [4:0]  act;
    logic [30:0] hz;
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    src_idle_pct   = 0;
    snk_stall_pct  = 0;
    ticks_sent     = 0;
    loads_sent     = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: ties, extremes, zero burst, zero period, load after ticks
    write_cfg(5'd4, 31'h7FFF_FFFF);
    send_load(4'd0, 16'd3, 16'd2);
    send_load(4'd1, 16'hFFFF, 16'hFFFF);
    send_load(4'd2, 16'd3, 16'd2);
    send_load(4'd3, 16'd0, 16'd0);
    send_load(4'd15, 16'd1, 16'd1);
    repeat (8) send_tick();
    send_load(4'd3, 16'd0, 16'd1);
    repeat (3) send_tick();
    settle();
    write_cfg(5'd0, 31'd0);
    repeat (2) send_tick();
    settle();
    write_cfg(5'd2, 31'd0);
    send_tick();
    send_load(4'd0, 16'd1, 16'd3);
    repeat (3) send_tick();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 73; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 73; end
        default: begin src_idle_pct = 31; snk_stall_pct = 31; end
      endcase
      case (p)
        0: begin act = 5'd16; hz = 31'h7FFF_FFFF; end
        1: begin act = 5'd1;  hz = 31'd0; end
        2: begin act = 5'd31; hz = 31'($urandom_range(500)); end
        3: begin act = 5'd0;  hz = 31'h7FFF_FFFF; end
        4: begin act = 5'($urandom_range(16, 1)); hz = 31'($urandom); end
        default: begin act = 5'($urandom_range(16, 1)); hz = 31'($urandom_range(3000)); end
      endcase
      settle();
      write_cfg(act, hz);
      // every slot loaded before any tick can look at it
      for (int s = 0; s < NUM_SLOTS; s++) send(rand_load(4'(s)));
      for (int n = 0; n < PHASE_LEN; n++) begin
        if ((p == 0 && n == 100) || $urandom_range(199) == 0) drain();
        if ($urandom_range(99) < 15) send(rand_load(4'($urandom)));
        else send_tick();
      end
    end

    settle();
    repeat (2 * LATENCY) @(posedge clk);
    $display("Covered %0d ticks and %0d task loads: directed prelude plus %0d random phases",
             ticks_sent, loads_sent, PHASES);
    $display("with active_tasks 0..31, horizon 0..max; %0d results checked, %0d job completions",
             results_seen, jobs_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/edft_pkg.sv
rtl/edft_stream_if.sv
rtl/edft_ram.sv
rtl/edft_ctrl.sv
rtl/edf_tick_scheduler.sv
sim/edft_sched_checker.sv
sim/tb_edf_tick_scheduler.sv
